>>> rtl/hmis_pkg.sv
// Shared constants and types for the hybrid merge insertion sorter.
`default_nettype none
package hmis_pkg;

    // Set size and field widths
    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int THR_W   = 7;
    localparam logic [THR_W-1:0] THR_RESET = 7'd8;

    // Register indexes (paddr[PADDR_W-1:2])
    localparam logic [PADDR_W-3:0] REG_RUN_THRESHOLD = 1'b0;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic                    insert;
        logic                    shift;
        logic signed [VAL_W-1:0] key;
    } t_cell_ctrl;

endpackage
`default_nettype wire

>>> rtl/hmis_cell.sv
// One cell of the sorting row: holds one value, inserts or shifts left.
`default_nettype none
module hmis_cell
    import hmis_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cell_ctrl              i_ctrl,
    // Neighbor toward the head of the row
    input  wire logic                    i_prev_valid,
    input  wire logic signed [VAL_W-1:0] i_prev_value,
    input  wire logic                    i_prev_keep,
    // Neighbor toward the tail of the row
    input  wire logic                    i_next_valid,
    input  wire logic signed [VAL_W-1:0] i_next_value,
    // Cell contents
    output logic                         o_valid,
    output logic signed [VAL_W-1:0]      o_value,
    output logic                         o_keep
);

    logic                    r_valid;
    logic                    n_valid;
    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;

    // Stored value stays put when it sorts at or before the new key
    assign o_keep  = r_valid && (r_value <= i_ctrl.key);
    assign o_valid = r_valid;
    assign o_value = r_value;

    // Next contents: insert the key here, take the head-side value, or shift out
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.insert) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_valid = 1'b1;
                    n_value = i_ctrl.key;
                end else begin
                    n_valid = i_prev_valid;
                    n_value = i_prev_value;
                end
            end
        end else if (i_ctrl.shift) begin
            n_valid = i_next_valid;
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
`default_nettype wire

>>> rtl/hybrid_merge_insertion_sorter.sv
// Top level: sorting cell row, load/emit control and configuration port.
`default_nettype none
// Values enter one request per cycle and are kept in ascending order as they
// arrive by a row of MAX_ITEMS cells; each request inserts its value in the
// cycle it is accepted, so the set is already sorted when the request flagged
// last_item is taken. The block then stalls its input and emits the set from
// the head of the row, one result per cycle while the output is not stalled,
// flagging the final one; after that a new set begins. Values beyond
// MAX_ITEMS are dropped. run_threshold is held and read back at address 0;
// the order of the results does not depend on it.
module hybrid_merge_insertion_sorter
    import hmis_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Input channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire logic                    i_last_item,
    // Output channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [VAL_W-1:0]      o_sorted_value,
    output logic                         o_last_result,
    // Configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADDR_W-1:0]      paddr,
    input  wire logic [PDATA_W-1:0]      pwdata,
    output logic      [PDATA_W-1:0]      prdata,
    output logic                         pready
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [THR_W-1:0] r_run_threshold;

    logic       in_take;
    logic       out_take;
    logic       cfg_write;
    t_cell_ctrl cell_ctrl;

    logic                    w_valid [MAX_ITEMS];
    logic signed [VAL_W-1:0] w_value [MAX_ITEMS];
    logic                    w_keep  [MAX_ITEMS];

    // Handshakes
    assign o_in_stall  = (r_state == ST_EMIT);
    assign in_take     = i_in_valid && (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_EMIT) && w_valid[0];
    assign out_take    = o_out_valid && !i_out_stall;

    // Result from the head of the row; final when the next cell is empty
    assign o_sorted_value = w_value[0];
    assign o_last_result  = !w_valid[1];

    // Row control
    always_comb begin
        cell_ctrl.insert = in_take && (r_count < CNT_W'(MAX_ITEMS));
        cell_ctrl.shift  = out_take;
        cell_ctrl.key    = i_value;
    end

    // Cell row
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic                    prev_valid;
        logic signed [VAL_W-1:0] prev_value;
        logic                    prev_keep;
        logic                    next_valid;
        logic signed [VAL_W-1:0] next_value;

        if (g == 0) begin : g_head
            assign prev_valid = 1'b0;
            assign prev_value = '0;
            assign prev_keep  = 1'b1;
        end else begin : g_body
            assign prev_valid = w_valid[g-1];
            assign prev_value = w_value[g-1];
            assign prev_keep  = w_keep[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_value = '0;
        end else begin : g_inner
            assign next_valid = w_valid[g+1];
            assign next_value = w_value[g+1];
        end

        hmis_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_prev_valid (prev_valid),
            .i_prev_value (prev_value),
            .i_prev_keep  (prev_keep),
            .i_next_valid (next_valid),
            .i_next_value (next_value),
            .o_valid      (w_valid[g]),
            .o_value      (w_value[g]),
            .o_keep       (w_keep[g])
        );
    end

    // Load / emit sequencing
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            ST_LOAD: begin
                if (in_take) begin
                    if (r_count < CNT_W'(MAX_ITEMS)) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_last_item) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_take && o_last_result) begin
                    n_state = ST_LOAD;
                    n_count = '0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_threshold <= THR_RESET;
        end else if (cfg_write && (paddr[PADDR_W-1:2] == REG_RUN_THRESHOLD)) begin
            r_run_threshold <= pwdata[THR_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            REG_RUN_THRESHOLD: prdata = {{(PDATA_W-THR_W){1'b0}}, r_run_threshold};
            default:           prdata = '0;
        endcase
    end

endmodule
`default_nettype wire
